// ----- sv/cic_pkg.sv -----
package cic_pkg;

    // Coordinate width actually used from each input field.
    localparam int CW = 32;

    // Offsets from vertex a and their products.
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int DETW = PW + 1;
    localparam int SQW = 2 * CW + 1;

    // Limb split of the squared lengths for the numerator products.
    localparam int LOW = CW + 1;
    localparam int PPW = LOW + 1 + DW;

    // Numerator and divisor magnitudes.
    localparam int NW = 3 * CW + 2;
    localparam int NSW = NW + 1;
    localparam int DDW = 2 * CW + 2;

    // Quotient bits below the clamp limit of 2^90 in Q16.16 units.
    localparam int QB = 91;
    localparam logic [QB-1:0] O_LIM = QB'(1) << (QB - 1);
    localparam int DIV_LAT = QB + 1;

    // Square root of a 64-bit value, one result bit per stage.
    localparam int SQ_IN = 64;
    localparam int SQ_OUT = 32;
    localparam int SQ_LAT = 32;

endpackage

// ----- sv/cic_div.sv -----
module cic_div
    import cic_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [NW-1:0]  i_num,
    input  logic [DDW-1:0] i_den,
    output logic [QB-1:0]  o_quot,
    output logic           o_ovf
);

    localparam int CMPW = DDW + QB;

    logic [NW-1:0]  r_rem [0:QB];
    logic [DDW-1:0] r_den [0:QB];
    logic [QB-1:0]  r_quo [0:QB];
    logic           r_ovf [0:QB];

    // Entry stage flags a quotient of 2^QB or more; the bit stages assume it is smaller.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_ovf[0] <= CMPW'(i_num) >= (CMPW'(i_den) << QB);
        end
    end

    // One restoring step per stage, most significant quotient bit first.
    for (genvar s = 1; s <= QB; s++) begin : g_step
        localparam int K = QB - s;
        logic [CMPW-1:0] w_trial;
        logic            w_take;

        assign w_trial = CMPW'(r_den[s-1]) << K;
        assign w_take  = CMPW'(r_rem[s-1]) >= w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_take ? NW'(CMPW'(r_rem[s-1]) - w_trial) : r_rem[s-1];
                r_den[s] <= r_den[s-1];
                r_ovf[s] <= r_ovf[s-1];
                r_quo[s] <= r_quo[s-1] | (w_take ? (QB'(1) << K) : QB'(0));
            end
        end
    end

    assign o_quot = r_quo[QB];
    assign o_ovf  = r_ovf[QB];

endmodule

// ----- sv/cic_isqrt.sv -----
module cic_isqrt
    import cic_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [SQ_IN-1:0]  i_x,
    output logic [SQ_OUT-1:0] o_root
);

    logic [SQ_IN-1:0] r_x [0:SQ_LAT-1];
    logic [SQ_IN-1:0] r_r [0:SQ_LAT-1];

    // Digit-by-digit square root: each stage settles one bit of the root.
    for (genvar j = 0; j < SQ_LAT; j++) begin : g_step
        localparam logic [SQ_IN-1:0] BIT = SQ_IN'(1) << (SQ_IN - 2 - 2 * j);
        logic [SQ_IN-1:0] w_xi;
        logic [SQ_IN-1:0] w_ri;
        logic [SQ_IN-1:0] w_sum;
        logic             w_ge;

        if (j == 0) begin : g_first
            assign w_xi = i_x;
            assign w_ri = '0;
        end else begin : g_next
            assign w_xi = r_x[j-1];
            assign w_ri = r_r[j-1];
        end

        assign w_sum = w_ri + BIT;
        assign w_ge  = w_xi >= w_sum;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[j] <= w_ge ? w_xi - w_sum : w_xi;
                r_r[j] <= w_ge ? (w_ri >> 1) + BIT : w_ri >> 1;
            end
        end
    end

    assign o_root = r_r[SQ_LAT-1][SQ_OUT-1:0];

endmodule

// ----- sv/circumcircle_incircle_test.sv -----
// Circumcircle and in-circle test.
// Input channel: i_valid with the triangle a, b, c and the query point q, all
// signed Q16.16; a transaction is taken when i_valid is high and o_stall is low.
// Output channel: o_valid with center, radius, margin and degenerate; the
// transaction completes when o_valid is high and i_stall is low.
// Throughput is one transaction per cycle while the receiver does not stall.
// From the input to o_valid: six front stages for offsets and products, two
// 92-stage restoring dividers for the center offset (one quotient bit per
// stage), six stages for center, radius squared and margin, a 32-stage square
// root and the output register. The divider and the square root set the depth.
// A zero determinant raises degenerate and zeroes all other result fields.
// Reset clears every valid bit of the pipeline; data registers are not reset.
// When the receiver stalls a valid result, the whole pipeline holds and o_stall
// rises, so nothing is dropped or repeated; bubbles keep moving otherwise.
module circumcircle_incircle_test
    import cic_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_ax,
    input  logic signed [31:0] i_ay,
    input  logic signed [31:0] i_bx,
    input  logic signed [31:0] i_by,
    input  logic signed [31:0] i_cx,
    input  logic signed [31:0] i_cy,
    input  logic signed [31:0] i_qx,
    input  logic signed [31:0] i_qy,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_center_x,
    output logic signed [31:0] o_center_y,
    output logic        [31:0] o_radius,
    output logic signed [63:0] o_margin,
    output logic               o_degenerate
);

    localparam int FRONT_LAT = 6;
    localparam int BACK_LAT = 6;
    localparam int LAT = FRONT_LAT + DIV_LAT + BACK_LAT + SQ_LAT + 1;
    localparam int MW = QB;
    localparam int OSW = MW + 1;
    localparam int CSW = OSW + 1;
    localparam int LPW = DW + 33;
    localparam int TW = DW + MW;
    localparam int MGW = TW + 2;

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic [SQW-1:0]       dsq;
        logic                 degen;
        logic                 neg_x;
        logic                 neg_y;
    } t_div_side;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [SQW-1:0]     dsq;
        logic               neg_x;
        logic               neg_y;
        logic               big;
        logic               degen;
    } t_back;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [63:0] margin;
        logic               rad_sat;
        logic               degen;
    } t_sq_side;

    function automatic logic [31:0] sat32(input logic [CSW-1:0] v);
        logic [31:0] res;
        if (v[CSW-1:31] == {(CSW - 31){v[CSW-1]}}) begin
            res = v[31:0];
        end else begin
            res = v[CSW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return res;
    endfunction

    function automatic logic [63:0] sat64(input logic [MGW-1:0] v);
        logic [63:0] res;
        if (v[MGW-1:63] == {(MGW - 63){v[MGW-1]}}) begin
            res = v[63:0];
        end else begin
            res = v[MGW-1] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end
        return res;
    endfunction

    logic           w_en;
    logic [LAT-1:0] r_vld;

    // The whole pipeline moves unless a finished result is held by the receiver.
    assign w_en    = !(r_vld[LAT-1] && i_stall);
    assign o_stall = r_vld[LAT-1] && i_stall;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Stage 1: offsets from vertex a.
    logic signed [CW-1:0] w_ax, w_ay, w_bx, w_by, w_cx, w_cy, w_qx, w_qy;
    logic signed [CW-1:0] r1_ax, r1_ay;
    logic signed [DW-1:0] r1_ba0, r1_ba1, r1_ca0, r1_ca1, r1_dx, r1_dy;

    assign w_ax = $signed(i_ax[CW-1:0]);
    assign w_ay = $signed(i_ay[CW-1:0]);
    assign w_bx = $signed(i_bx[CW-1:0]);
    assign w_by = $signed(i_by[CW-1:0]);
    assign w_cx = $signed(i_cx[CW-1:0]);
    assign w_cy = $signed(i_cy[CW-1:0]);
    assign w_qx = $signed(i_qx[CW-1:0]);
    assign w_qy = $signed(i_qy[CW-1:0]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ax  <= w_ax;
            r1_ay  <= w_ay;
            r1_ba0 <= DW'(w_bx) - DW'(w_ax);
            r1_ba1 <= DW'(w_by) - DW'(w_ay);
            r1_ca0 <= DW'(w_cx) - DW'(w_ax);
            r1_ca1 <= DW'(w_cy) - DW'(w_ay);
            r1_dx  <= DW'(w_qx) - DW'(w_ax);
            r1_dy  <= DW'(w_qy) - DW'(w_ay);
        end
    end

    // Stage 2: determinant products and squares.
    logic signed [CW-1:0] r2_ax, r2_ay;
    logic signed [DW-1:0] r2_ba0, r2_ba1, r2_ca0, r2_ca1, r2_dx, r2_dy;
    logic signed [PW-1:0] r2_pbc, r2_pcb, r2_sba0, r2_sba1, r2_sca0, r2_sca1, r2_sdx, r2_sdy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_ba0  <= r1_ba0;
            r2_ba1  <= r1_ba1;
            r2_ca0  <= r1_ca0;
            r2_ca1  <= r1_ca1;
            r2_dx   <= r1_dx;
            r2_dy   <= r1_dy;
            r2_pbc  <= PW'(r1_ba0) * PW'(r1_ca1);
            r2_pcb  <= PW'(r1_ca0) * PW'(r1_ba1);
            r2_sba0 <= PW'(r1_ba0) * PW'(r1_ba0);
            r2_sba1 <= PW'(r1_ba1) * PW'(r1_ba1);
            r2_sca0 <= PW'(r1_ca0) * PW'(r1_ca0);
            r2_sca1 <= PW'(r1_ca1) * PW'(r1_ca1);
            r2_sdx  <= PW'(r1_dx) * PW'(r1_dx);
            r2_sdy  <= PW'(r1_dy) * PW'(r1_dy);
        end
    end

    // Stage 3: determinant and squared lengths.
    logic signed [CW-1:0]   r3_ax, r3_ay;
    logic signed [DW-1:0]   r3_ba0, r3_ba1, r3_ca0, r3_ca1, r3_dx, r3_dy;
    logic signed [DETW-1:0] r3_det;
    logic [SQW-1:0]         r3_asq, r3_csq, r3_dsq;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_ax  <= r2_ax;
            r3_ay  <= r2_ay;
            r3_ba0 <= r2_ba0;
            r3_ba1 <= r2_ba1;
            r3_ca0 <= r2_ca0;
            r3_ca1 <= r2_ca1;
            r3_dx  <= r2_dx;
            r3_dy  <= r2_dy;
            r3_det <= DETW'(r2_pbc) - DETW'(r2_pcb);
            r3_asq <= SQW'(r2_sba0 + r2_sba1);
            r3_csq <= SQW'(r2_sca0 + r2_sca1);
            r3_dsq <= SQW'(r2_sdx + r2_sdy);
        end
    end

    // Stage 4: limb products of the numerators and the divisor magnitude.
    logic [DETW-1:0]       w_det_abs;
    logic signed [CW-1:0]  r4_ax, r4_ay;
    logic signed [DW-1:0]  r4_dx, r4_dy;
    logic [SQW-1:0]        r4_dsq;
    logic signed [PPW-1:0] r4_al_c1, r4_ah_c1, r4_cl_b1, r4_ch_b1;
    logic signed [PPW-1:0] r4_cl_b0, r4_ch_b0, r4_al_c0, r4_ah_c0;
    logic [DDW-1:0]        r4_dabs;
    logic                  r4_dneg, r4_degen;

    assign w_det_abs = r3_det[DETW-1] ? -r3_det : r3_det;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_ax    <= r3_ax;
            r4_ay    <= r3_ay;
            r4_dx    <= r3_dx;
            r4_dy    <= r3_dy;
            r4_dsq   <= r3_dsq;
            r4_al_c1 <= PPW'($signed({1'b0, r3_asq[LOW-1:0]})) * PPW'(r3_ca1);
            r4_ah_c1 <= PPW'($signed({1'b0, r3_asq[SQW-1:LOW]})) * PPW'(r3_ca1);
            r4_cl_b1 <= PPW'($signed({1'b0, r3_csq[LOW-1:0]})) * PPW'(r3_ba1);
            r4_ch_b1 <= PPW'($signed({1'b0, r3_csq[SQW-1:LOW]})) * PPW'(r3_ba1);
            r4_cl_b0 <= PPW'($signed({1'b0, r3_csq[LOW-1:0]})) * PPW'(r3_ba0);
            r4_ch_b0 <= PPW'($signed({1'b0, r3_csq[SQW-1:LOW]})) * PPW'(r3_ba0);
            r4_al_c0 <= PPW'($signed({1'b0, r3_asq[LOW-1:0]})) * PPW'(r3_ca0);
            r4_ah_c0 <= PPW'($signed({1'b0, r3_asq[SQW-1:LOW]})) * PPW'(r3_ca0);
            r4_dabs  <= {w_det_abs[DDW-2:0], 1'b0};
            r4_dneg  <= r3_det[DETW-1];
            r4_degen <= (r3_det == '0);
        end
    end

    // Stage 5: numerators of the center offset.
    logic signed [CW-1:0]  r5_ax, r5_ay;
    logic signed [DW-1:0]  r5_dx, r5_dy;
    logic [SQW-1:0]        r5_dsq;
    logic signed [NSW-1:0] r5_n0, r5_n1;
    logic [DDW-1:0]        r5_dabs;
    logic                  r5_dneg, r5_degen;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_ax    <= r4_ax;
            r5_ay    <= r4_ay;
            r5_dx    <= r4_dx;
            r5_dy    <= r4_dy;
            r5_dsq   <= r4_dsq;
            r5_dabs  <= r4_dabs;
            r5_dneg  <= r4_dneg;
            r5_degen <= r4_degen;
            r5_n0    <= (NSW'(r4_ah_c1) << LOW) + NSW'(r4_al_c1)
                      - (NSW'(r4_ch_b1) << LOW) - NSW'(r4_cl_b1);
            r5_n1    <= (NSW'(r4_ch_b0) << LOW) + NSW'(r4_cl_b0)
                      - (NSW'(r4_ah_c0) << LOW) - NSW'(r4_al_c0);
        end
    end

    // Stage 6: magnitudes and quotient signs.
    logic [NW-1:0]  r6_nabs0, r6_nabs1;
    logic [DDW-1:0] r6_dabs;
    t_div_side      r6_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_nabs0      <= r5_n0[NSW-1] ? NW'(-r5_n0) : NW'(r5_n0);
            r6_nabs1      <= r5_n1[NSW-1] ? NW'(-r5_n1) : NW'(r5_n1);
            r6_dabs       <= r5_dabs;
            r6_side.ax    <= r5_ax;
            r6_side.ay    <= r5_ay;
            r6_side.dx    <= r5_dx;
            r6_side.dy    <= r5_dy;
            r6_side.dsq   <= r5_dsq;
            r6_side.degen <= r5_degen;
            r6_side.neg_x <= r5_n0[NSW-1] ^ r5_dneg;
            r6_side.neg_y <= r5_n1[NSW-1] ^ r5_dneg;
        end
    end

    // Center offset quotients, one divider per axis.
    logic [QB-1:0] w_qx_quot, w_qy_quot;
    logic          w_qx_ovf, w_qy_ovf;
    t_div_side     r_dl [0:DIV_LAT-1];

    cic_div u_div_x (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r6_nabs0),
        .i_den  (r6_dabs),
        .o_quot (w_qx_quot),
        .o_ovf  (w_qx_ovf)
    );

    cic_div u_div_y (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r6_nabs1),
        .i_den  (r6_dabs),
        .o_quot (w_qy_quot),
        .o_ovf  (w_qy_ovf)
    );

    // Side data travels beside the dividers.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl[0] <= r6_side;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_dl[k] <= r_dl[k-1];
            end
        end
    end

    // Back stage 1: clamp the quotients and apply their signs.
    logic [MW-1:0]         w_magx, w_magy;
    logic [MW-1:0]         r7_magx, r7_magy;
    logic signed [OSW-1:0] r7_ox, r7_oy;
    logic                  r7_big;
    t_div_side             r7_side;

    assign w_magx = (w_qx_ovf || w_qx_quot > O_LIM) ? O_LIM : w_qx_quot;
    assign w_magy = (w_qy_ovf || w_qy_quot > O_LIM) ? O_LIM : w_qy_quot;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_magx <= w_magx;
            r7_magy <= w_magy;
            r7_ox   <= r_dl[DIV_LAT-1].neg_x ? -OSW'(w_magx) : OSW'(w_magx);
            r7_oy   <= r_dl[DIV_LAT-1].neg_y ? -OSW'(w_magy) : OSW'(w_magy);
            r7_big  <= (|w_magx[MW-1:32]) || (|w_magy[MW-1:32]);
            r7_side <= r_dl[DIV_LAT-1];
        end
    end

    // Back stage 2: saturated center, margin limb products, radius squares.
    logic signed [LPW-1:0] r8_px0, r8_px1, r8_px2, r8_py0, r8_py1, r8_py2;
    logic [63:0]           r8_sqx, r8_sqy;
    t_back                 r8_bk;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_bk.cx    <= sat32(CSW'($signed(r7_side.ax)) + CSW'(r7_ox));
            r8_bk.cy    <= sat32(CSW'($signed(r7_side.ay)) + CSW'(r7_oy));
            r8_bk.dsq   <= r7_side.dsq;
            r8_bk.neg_x <= r7_side.neg_x;
            r8_bk.neg_y <= r7_side.neg_y;
            r8_bk.big   <= r7_big;
            r8_bk.degen <= r7_side.degen;
            r8_px0 <= LPW'($signed(r7_side.dx)) * LPW'($signed({1'b0, r7_magx[31:0]}));
            r8_px1 <= LPW'($signed(r7_side.dx)) * LPW'($signed({1'b0, r7_magx[63:32]}));
            r8_px2 <= LPW'($signed(r7_side.dx)) * LPW'($signed({1'b0, r7_magx[MW-1:64]}));
            r8_py0 <= LPW'($signed(r7_side.dy)) * LPW'($signed({1'b0, r7_magy[31:0]}));
            r8_py1 <= LPW'($signed(r7_side.dy)) * LPW'($signed({1'b0, r7_magy[63:32]}));
            r8_py2 <= LPW'($signed(r7_side.dy)) * LPW'($signed({1'b0, r7_magy[MW-1:64]}));
            r8_sqx <= 64'(r7_magx[31:0]) * 64'(r7_magx[31:0]);
            r8_sqy <= 64'(r7_magy[31:0]) * 64'(r7_magy[31:0]);
        end
    end

    // Back stage 3: recombine the limb products and sum the squares.
    logic signed [TW-1:0] r9_tx, r9_ty;
    logic [64:0]          r9_r2;
    t_back                r9_bk;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_tx <= TW'(r8_px0) + (TW'(r8_px1) << 32) + (TW'(r8_px2) << 64);
            r9_ty <= TW'(r8_py0) + (TW'(r8_py1) << 32) + (TW'(r8_py2) << 64);
            r9_r2 <= 65'(r8_sqx) + 65'(r8_sqy);
            r9_bk <= r8_bk;
        end
    end

    // Back stage 4: signed dot terms and the radius overflow check.
    logic signed [TW-1:0] r10_tx, r10_ty;
    logic [63:0]          r10_r2;
    t_back                r10_bk;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r10_tx       <= r9_bk.neg_x ? -r9_tx : r9_tx;
            r10_ty       <= r9_bk.neg_y ? -r9_ty : r9_ty;
            r10_r2       <= r9_r2[63:0];
            r10_bk.cx    <= r9_bk.cx;
            r10_bk.cy    <= r9_bk.cy;
            r10_bk.dsq   <= r9_bk.dsq;
            r10_bk.neg_x <= r9_bk.neg_x;
            r10_bk.neg_y <= r9_bk.neg_y;
            r10_bk.degen <= r9_bk.degen;
            r10_bk.big   <= r9_bk.big || r9_r2[64];
        end
    end

    // Back stage 5: margin as twice the dot product minus the squared distance.
    logic signed [MGW-1:0] r11_m;
    logic [63:0]           r11_r2;
    t_back                 r11_bk;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r11_m  <= ((MGW'(r10_tx) + MGW'(r10_ty)) << 1) - $signed(MGW'(r10_bk.dsq));
            r11_r2 <= r10_r2;
            r11_bk <= r10_bk;
        end
    end

    // Back stage 6: saturate the margin.
    logic [63:0] r12_r2;
    t_sq_side    r12_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r12_r2           <= r11_r2;
            r12_side.cx      <= r11_bk.cx;
            r12_side.cy      <= r11_bk.cy;
            r12_side.margin  <= sat64(r11_m);
            r12_side.rad_sat <= r11_bk.big;
            r12_side.degen   <= r11_bk.degen;
        end
    end

    // Radius as the integer square root of the squared offset.
    logic [SQ_OUT-1:0] w_root;
    t_sq_side          r_sl [0:SQ_LAT-1];

    cic_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    (r12_r2),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sl[0] <= r12_side;
            for (int k = 1; k < SQ_LAT; k++) begin
                r_sl[k] <= r_sl[k-1];
            end
        end
    end

    // Output register; a degenerate triangle gives zeros.
    logic signed [31:0] r_out_cx, r_out_cy;
    logic [31:0]        r_out_rad;
    logic signed [63:0] r_out_margin;
    logic               r_out_degen;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_degen <= r_sl[SQ_LAT-1].degen;
            if (r_sl[SQ_LAT-1].degen) begin
                r_out_cx     <= '0;
                r_out_cy     <= '0;
                r_out_rad    <= '0;
                r_out_margin <= '0;
            end else begin
                r_out_cx     <= r_sl[SQ_LAT-1].cx;
                r_out_cy     <= r_sl[SQ_LAT-1].cy;
                r_out_rad    <= r_sl[SQ_LAT-1].rad_sat ? 32'hFFFF_FFFF : w_root;
                r_out_margin <= r_sl[SQ_LAT-1].margin;
            end
        end
    end

    assign o_center_x   = r_out_cx;
    assign o_center_y   = r_out_cy;
    assign o_radius     = r_out_rad;
    assign o_margin     = r_out_margin;
    assign o_degenerate = r_out_degen;

endmodule

// ----- bench/tb_circumcircle_incircle_test.sv -----
module tb_circumcircle_incircle_test;
    import cic_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One triangle with its query point, and one circle test result.
    typedef struct {
        logic signed [31:0] ax, ay, bx, by, cx, cy, qx, qy;
    } t_tri;

    typedef struct {
        logic signed [31:0] center_x, center_y;
        logic        [31:0] radius;
        logic signed [63:0] margin;
        logic               degenerate;
    } t_circ;

    typedef logic signed [255:0] t_wide;

    // Scoreboard: predicts each circle from an accepted triangle and matches
    // the results in order.
    class circle_ledger;
        t_circ pending_circles[$];
        int    mismatches;

        function automatic logic [31:0] floor_sqrt(logic [63:0] x);
            logic [31:0]  res;
            logic [127:0] cand;
            res = '0;
            for (int i = 31; i >= 0; i--) begin
                cand = 128'(res | (32'd1 << i));
                if (cand * cand <= 128'(x))
                    res = res | (32'd1 << i);
            end
            return res;
        endfunction

        function automatic logic signed [31:0] clip32(t_wide v);
            if (v > t_wide'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
            if (v < -t_wide'(64'sh80000000)) return 32'sh80000000;
            return v[31:0];
        endfunction

        function automatic t_circ predict_circle(t_tri t);
            t_wide ax, ay, bax, bay, cax, cay, dx, dy, det, asq, csq;
            t_wide n0, n1, ox, oy, lim, r2, m, big, m_hi, m_lo;
            t_circ r;
            ax  = t.ax;
            ay  = t.ay;
            bax = t_wide'(t.bx) - ax;
            bay = t_wide'(t.by) - ay;
            cax = t_wide'(t.cx) - ax;
            cay = t_wide'(t.cy) - ay;
            dx  = t_wide'(t.qx) - ax;
            dy  = t_wide'(t.qy) - ay;
            det = bax * cay - cax * bay;
            r = '{default: '0};
            // Collinear vertices give the flag and an all-zero result.
            if (det == 0) begin
                r.degenerate = 1'b1;
                return r;
            end
            asq = bax * bax + bay * bay;
            csq = cax * cax + cay * cay;
            n0  = asq * cay - csq * bay;
            n1  = csq * bax - asq * cax;
            ox  = n0 / (det + det);
            oy  = n1 / (det + det);
            lim = 1;
            lim = lim << 90;
            if (ox > lim) ox = lim;
            if (ox < -lim) ox = -lim;
            if (oy > lim) oy = lim;
            if (oy < -lim) oy = -lim;
            r.center_x = clip32(ax + ox);
            r.center_y = clip32(ay + oy);
            // Radius saturates once an offset reaches 2^32 or the squared radius reaches 2^64.
            big = 1;
            big = big << 32;
            if (ox >= big || ox <= -big || oy >= big || oy <= -big) begin
                r.radius = '1;
            end else begin
                r2 = ox * ox + oy * oy;
                if (r2 >= (big * big)) r.radius = '1;
                else r.radius = floor_sqrt(r2[63:0]);
            end
            m = 2 * (dx * ox + dy * oy) - (dx * dx + dy * dy);
            m_hi = t_wide'(64'sh7FFFFFFFFFFFFFFF);
            m_lo = -m_hi - 1;
            if (m > m_hi) r.margin = m_hi[63:0];
            else if (m < m_lo) r.margin = m_lo[63:0];
            else r.margin = m[63:0];
            return r;
        endfunction

        function void note_triangle(t_tri t);
            pending_circles.push_back(predict_circle(t));
        endfunction

        function void check_result(t_circ got);
            t_circ exp_c;
            if (pending_circles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transaction: center %0d,%0d",
                             got.center_x, got.center_y);
                return;
            end
            exp_c = pending_circles.pop_front();
            if (got.center_x !== exp_c.center_x || got.center_y !== exp_c.center_y ||
                got.radius !== exp_c.radius || got.margin !== exp_c.margin ||
                got.degenerate !== exp_c.degenerate) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: exp c=(%0d,%0d) r=%0d m=%0d dg=%0b",
                             exp_c.center_x, exp_c.center_y, exp_c.radius,
                             exp_c.margin, exp_c.degenerate,
                             " got c=(%0d,%0d) r=%0d m=%0d dg=%0b",
                             got.center_x, got.center_y, got.radius,
                             got.margin, got.degenerate);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_ax, i_ay, i_bx, i_by, i_cx, i_cy, i_qx, i_qy;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_center_x, o_center_y;
    logic        [31:0] o_radius;
    logic signed [63:0] o_margin;
    logic               o_degenerate;

    circle_ledger ledger = new();
    bit calm_phase;
    bit hold_go;
    bit hold_done;
    int hold_left;
    int stall_left;

    circumcircle_incircle_test u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_ax        (i_ax),
        .i_ay        (i_ay),
        .i_bx        (i_bx),
        .i_by        (i_by),
        .i_cx        (i_cx),
        .i_cy        (i_cy),
        .i_qx        (i_qx),
        .i_qy        (i_qy),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_center_x  (o_center_x),
        .o_center_y  (o_center_y),
        .o_radius    (o_radius),
        .o_margin    (o_margin),
        .o_degenerate(o_degenerate)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Receiver back-pressure: random stalls plus one long hold-off.
    always @(negedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall = 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall = 1'b1;
        end else if (calm_phase) begin
            i_stall = 1'b0;
        end else begin
            int roll;
            roll = $urandom_range(99);
            i_stall = 1'b0;
            if (roll >= 95) stall_left = $urandom_range(40, 10);
            else if (roll >= 70) stall_left = $urandom_range(3, 1);
        end
    end

    // Result transactions are checked at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            ledger.check_result('{o_center_x, o_center_y, o_radius, o_margin, o_degenerate});
    end

    task automatic send_triangle(t_tri t);
        int gap;
        gap = 0;
        if (!calm_phase) begin
            int roll;
            roll = $urandom_range(99);
            if (roll >= 92) gap = $urandom_range(40, 10);
            else if (roll >= 60) gap = $urandom_range(3, 1);
        end
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        {i_ax, i_ay, i_bx, i_by, i_cx, i_cy, i_qx, i_qy} =
            {t.ax, t.ay, t.bx, t.by, t.cx, t.cy, t.qx, t.qy};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        ledger.note_triangle(t);
    endtask

    function automatic logic signed [31:0] near(logic signed [31:0] base, int span);
        return base + $signed($urandom_range(2 * span)) - span;
    endfunction

    // Random triangle drawn from one of several shapes.
    function automatic t_tri random_triangle();
        t_tri t;
        int   kind, k;
        logic signed [31:0] base_x, base_y;
        kind = $urandom_range(99);
        base_x = ($urandom_range(1)) ? $urandom : near(0, 1 << 24);
        base_y = ($urandom_range(1)) ? $urandom : near(0, 1 << 24);
        t.ax = base_x;
        t.ay = base_y;
        t.bx = near(base_x, 1 << 20);
        t.by = near(base_y, 1 << 20);
        t.cx = near(base_x, 1 << 20);
        t.cy = near(base_y, 1 << 20);
        t.qx = near(base_x, 1 << 20);
        t.qy = near(base_y, 1 << 20);
        if (kind < 12) begin
            t = '{$urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom};
        end else if (kind < 24) begin
            // Collinear: c lies on the line through a and b.
            k = $urandom_range(6) - 3;
            t.cx = t.ax + k * (t.bx - t.ax);
            t.cy = t.ay + k * (t.by - t.ay);
        end else if (kind < 44) begin
            // Query close to a vertex, so the margin sits near zero.
            t.qx = near(t.bx, 4);
            t.qy = near(t.by, 4);
        end else if (kind < 54) begin
            t.ax = ($urandom_range(1)) ? 32'sh7FFFFFFF : 32'sh80000000;
            t.qy = ($urandom_range(1)) ? 32'sh7FFFFFFF : 32'sh80000000;
            t.cx = $urandom;
        end else if (kind < 64) begin
            // Tiny triangles in raw units.
            t.bx = near(base_x, 3);
            t.by = near(base_y, 3);
            t.cx = near(base_x, 3);
            t.cy = near(base_y, 3);
        end
        return t;
    endfunction

    localparam logic signed [31:0] ONE = 32'sh00010000;
    localparam logic signed [31:0] PMAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] NMAX = 32'sh80000000;

    initial begin
        t_tri directed[$];
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        {i_ax, i_ay, i_bx, i_by, i_cx, i_cy, i_qx, i_qy} = '0;
        calm_phase = 1'b0;
        hold_go = 1'b0;
        hold_done = 1'b0;
        hold_left = 0;
        stall_left = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed cases: degenerate shapes, small circles, field extremes.
        directed = '{
            '{0, 0, 0, 0, 0, 0, 0, 0},
            '{ONE, ONE, ONE, ONE, ONE, ONE, 0, 0},
            '{0, 0, ONE, 0, 2 * ONE, 0, ONE, ONE},
            '{0, 0, 2 * ONE, 0, 0, 2 * ONE, ONE, ONE},
            '{0, 0, 2 * ONE, 0, 0, 2 * ONE, 2 * ONE, 0},
            '{0, 0, 2 * ONE, 0, 0, 2 * ONE, 9 * ONE, -9 * ONE},
            '{0, 0, 1, 0, 0, 1, 0, 0},
            '{0, 0, 0, 1, 1, 0, 1, 1},
            '{NMAX, NMAX, PMAX, NMAX, NMAX, PMAX, PMAX, PMAX},
            '{PMAX, PMAX, NMAX, PMAX, PMAX, NMAX, NMAX, NMAX},
            '{PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX},
            '{NMAX, NMAX, NMAX, NMAX, NMAX, NMAX, NMAX, NMAX},
            '{NMAX, 0, PMAX, 1, 0, -1, NMAX, PMAX},
            '{0, 0, PMAX, 0, NMAX, 1, 0, 0},
            '{0, 0, PMAX, 1, NMAX, 0, PMAX, NMAX},
            '{NMAX, NMAX, NMAX + ONE, NMAX, NMAX, NMAX + ONE, PMAX, PMAX},
            '{PMAX, 0, PMAX - 1, 0, PMAX, 1, NMAX, 0},
            '{-ONE, -ONE, ONE, -ONE, -ONE, ONE, -ONE, -ONE},
            '{32'sh55555555, 32'shAAAAAAAA, 32'shAAAAAAAA, 32'sh55555555,
              32'sh0F0F0F0F, 32'shF0F0F0F0, 32'sh12345678, 32'shEDCBA987}
        };
        foreach (directed[i]) send_triangle(directed[i]);

        // Random part, with one long receiver hold-off early on.
        hold_go = 1'b1;
        for (int n = 0; n < 1230; n++) begin
            calm_phase = (n >= 600 && n < 750);
            send_triangle(random_triangle());
        end
        @(negedge i_clk);
        i_valid = 1'b0;
        calm_phase = 1'b0;

        while (ledger.pending_circles.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (ledger.mismatches == 0 && ledger.pending_circles.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog for a hung pipeline.
    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- circumcircle_incircle_test.f -----
sv/cic_pkg.sv
sv/cic_div.sv
sv/cic_isqrt.sv
sv/circumcircle_incircle_test.sv
bench/tb_circumcircle_incircle_test.sv
